// File: design/fwbrr_pkg.sv
package fwbrr_pkg;

   // Command codes carried in the request tuser bit.
   localparam logic CMD_ENQUEUE = 1'b0;
   localparam logic CMD_SERVE   = 1'b1;

   // Configuration register indexes.
   localparam logic CSR_START_DIRECTION = 1'b0;
   localparam logic CSR_MAX_BURST       = 1'b1;

   localparam int TAG_W   = 24;
   localparam int DUR_W   = 4;
   localparam int DIR_W   = 2;
   localparam int BURST_W = 8;
   localparam int ENTRY_W = TAG_W + DUR_W;

   localparam logic [BURST_W-1:0] BURST_SAT = 8'd255;

   typedef enum logic [1:0] {
      STAT_ENQUEUED = 2'd0,
      STAT_DROPPED  = 2'd1,
      STAT_GRANTED  = 2'd2,
      STAT_EMPTY    = 2'd3
   } status_type;

   typedef enum logic {
      BACK_IDLE,
      BACK_READ
   } back_state_type;

   // One classified command as handed from the front to the back.
   typedef struct packed {
      logic             serve;
      logic [DIR_W-1:0] dir;
      logic [TAG_W-1:0] tag;
      logic [DUR_W-1:0] dur;
   } cmd_type;

endpackage

// File: design/fwbrr_front.sv
module fwbrr_front
   import fwbrr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,
   input  logic        req_tuser,
   output logic        cmd_valid,
   input  logic        cmd_ready,
   output cmd_type     cmd
);

   // Two-entry command queue between the stream input and the scheduler.
   cmd_type    ent_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] fill_ff, fill_in;
   cmd_type    incoming;
   logic       push, pop;

   always_comb begin
      incoming.serve = (req_tuser == CMD_SERVE);
      incoming.dir   = req_tdata[1:0];
      incoming.tag   = req_tdata[25:2];
      incoming.dur   = req_tdata[29:26];
   end

   assign req_tready = (fill_ff != 2'd2);
   assign cmd_valid  = (fill_ff != 2'd0);
   assign cmd        = ent_ff[rd_ptr_ff];
   assign push       = req_tvalid && req_tready;
   assign pop        = cmd_valid && cmd_ready;

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      fill_in   = fill_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         ent_ff[wr_ptr_ff] <= incoming;
      end
   end

endmodule

// File: design/fwbrr_back.sv
module fwbrr_back
   import fwbrr_pkg::*;
#(
   parameter int QUEUE_DEPTH = 16
)
(
   input  logic         clock,
   input  logic         reset,
   input  logic         csr_we,
   input  logic         csr_index,
   input  logic [7:0]   csr_wdata,
   input  logic         cmd_valid,
   output logic         cmd_ready,
   input  cmd_type      cmd,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [31:0]  rsp_tdata,
   output logic [1:0]   rsp_tuser
);

   localparam int SLOT_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
   localparam int SUM_W  = ((SLOT_W > CNT_W) ? SLOT_W : CNT_W) + 1;

   logic [ENTRY_W-1:0] mem [4][QUEUE_DEPTH];
   logic [ENTRY_W-1:0] mem_rd_ff;

   back_state_type     state_ff, state_in;
   logic [SLOT_W-1:0]  heads_ff [4];
   logic [SLOT_W-1:0]  heads_in [4];
   logic [CNT_W-1:0]   counts_ff [4];
   logic [CNT_W-1:0]   counts_in [4];
   logic [DIR_W-1:0]   cur_ff, cur_in;
   logic [BURST_W-1:0] burst_ff, burst_in;
   logic [DIR_W-1:0]   start_ff, start_in;
   logic [BURST_W-1:0] max_ff, max_in;
   logic [DIR_W-1:0]   gdir_ff, gdir_in;
   logic               gnew_ff, gnew_in;

   logic               out_valid_ff, out_valid_in;
   status_type         out_status_ff, out_status_in;
   logic [DIR_W-1:0]   out_dir_ff, out_dir_in;
   logic [TAG_W-1:0]   out_tag_ff, out_tag_in;
   logic [DUR_W-1:0]   out_dur_ff, out_dur_in;
   logic               out_new_ff, out_new_in;

   logic               take, found, full;
   logic [DIR_W-1:0]   sel_dir, cand;
   logic [SUM_W-1:0]   tail_sum, head_inc;
   logic [SLOT_W-1:0]  wr_slot, next_head;
   logic [BURST_W-1:0] burst_base, burst_inc;
   logic               mem_we, mem_re;

   // First non-empty queue clockwise from the current direction.
   always_comb begin
      found   = 1'b0;
      sel_dir = cur_ff;
      cand    = cur_ff;
      for (int k = 0; k < 4; k++) begin
         cand = cur_ff + DIR_W'(k);
         if (!found && (counts_ff[cand] != '0)) begin
            found   = 1'b1;
            sel_dir = cand;
         end
      end
   end

   always_comb begin
      full     = (counts_ff[cmd.dir] == CNT_W'(QUEUE_DEPTH));
      tail_sum = SUM_W'(heads_ff[cmd.dir]) + SUM_W'(counts_ff[cmd.dir]);
      wr_slot  = (tail_sum >= SUM_W'(QUEUE_DEPTH)) ?
                 SLOT_W'(tail_sum - SUM_W'(QUEUE_DEPTH)) : SLOT_W'(tail_sum);
      head_inc  = SUM_W'(heads_ff[sel_dir]) + SUM_W'(1);
      next_head = (head_inc == SUM_W'(QUEUE_DEPTH)) ? '0 : SLOT_W'(head_inc);
      // A turn to another direction starts a fresh burst.
      burst_base = (sel_dir != cur_ff) ? '0 : burst_ff;
      burst_inc  = (burst_base < BURST_SAT) ? burst_base + BURST_W'(1) : BURST_SAT;
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BACK_IDLE: begin
            if (take && cmd.serve && found) begin
               state_in = BACK_READ;
            end
         end
         BACK_READ: begin
            state_in = BACK_IDLE;
         end
         default: state_in = BACK_IDLE;
      endcase
   end

   // Outputs and datapath updates.
   always_comb begin
      cmd_ready     = (state_ff == BACK_IDLE) && (!out_valid_ff || rsp_tready);
      take          = cmd_ready && cmd_valid;
      heads_in      = heads_ff;
      counts_in     = counts_ff;
      cur_in        = cur_ff;
      burst_in      = burst_ff;
      start_in      = start_ff;
      max_in        = max_ff;
      gdir_in       = gdir_ff;
      gnew_in       = gnew_ff;
      mem_we        = 1'b0;
      mem_re        = 1'b0;
      out_valid_in  = out_valid_ff && !rsp_tready;
      out_status_in = out_status_ff;
      out_dir_in    = out_dir_ff;
      out_tag_in    = out_tag_ff;
      out_dur_in    = out_dur_ff;
      out_new_in    = out_new_ff;

      unique case (state_ff)
         BACK_IDLE: begin
            if (take) begin
               if (!cmd.serve) begin
                  out_valid_in  = 1'b1;
                  out_dir_in    = '0;
                  out_tag_in    = '0;
                  out_dur_in    = '0;
                  out_new_in    = 1'b0;
                  if (full) begin
                     out_status_in = STAT_DROPPED;
                  end else begin
                     out_status_in      = STAT_ENQUEUED;
                     mem_we             = 1'b1;
                     counts_in[cmd.dir] = counts_ff[cmd.dir] + CNT_W'(1);
                  end
               end else if (!found) begin
                  out_valid_in  = 1'b1;
                  out_status_in = STAT_EMPTY;
                  out_dir_in    = '0;
                  out_tag_in    = '0;
                  out_dur_in    = '0;
                  out_new_in    = 1'b0;
               end else begin
                  mem_re             = 1'b1;
                  gdir_in            = sel_dir;
                  gnew_in            = (burst_base == '0);
                  heads_in[sel_dir]  = next_head;
                  counts_in[sel_dir] = counts_ff[sel_dir] - CNT_W'(1);
                  if ((max_ff != '0) && (burst_inc >= max_ff)) begin
                     burst_in = '0;
                     cur_in   = sel_dir + DIR_W'(1);
                  end else begin
                     burst_in = burst_inc;
                     cur_in   = sel_dir;
                  end
               end
            end
         end
         BACK_READ: begin
            out_valid_in  = 1'b1;
            out_status_in = STAT_GRANTED;
            out_dir_in    = gdir_ff;
            out_tag_in    = mem_rd_ff[ENTRY_W-1:DUR_W];
            out_dur_in    = mem_rd_ff[DUR_W-1:0];
            out_new_in    = gnew_ff;
         end
         default: begin
         end
      endcase

      if (csr_we) begin
         unique case (csr_index)
            CSR_START_DIRECTION: begin
               start_in = csr_wdata[DIR_W-1:0];
               cur_in   = csr_wdata[DIR_W-1:0];
               burst_in = '0;
            end
            CSR_MAX_BURST: begin
               max_in = csr_wdata;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BACK_IDLE;
         heads_ff     <= '{default: '0};
         counts_ff    <= '{default: '0};
         cur_ff       <= '0;
         burst_ff     <= '0;
         start_ff     <= '0;
         max_ff       <= BURST_W'(1);
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         heads_ff     <= heads_in;
         counts_ff    <= counts_in;
         cur_ff       <= cur_in;
         burst_ff     <= burst_in;
         start_ff     <= start_in;
         max_ff       <= max_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      gdir_ff       <= gdir_in;
      gnew_ff       <= gnew_in;
      out_status_ff <= out_status_in;
      out_dir_ff    <= out_dir_in;
      out_tag_ff    <= out_tag_in;
      out_dur_ff    <= out_dur_in;
      out_new_ff    <= out_new_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[cmd.dir][wr_slot] <= {cmd.tag, cmd.dur};
      end
      if (mem_re) begin
         mem_rd_ff <= mem[sel_dir][heads_ff[sel_dir]];
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_status_ff;
   assign rsp_tdata  = {1'b0, out_new_ff, out_dur_ff, out_tag_ff, out_dir_ff};

endmodule

// File: design/four_way_burst_round_robin_scheduler_top.sv
// Four-way burst round-robin scheduler. Requests are enqueued into one of four
// direction queues (north, east, south, west) and a serve transaction grants the
// oldest request of the current direction, turning clockwise past empty queues
// or after max_burst grants in a row (max_burst of zero means no limit). Every
// input transaction yields exactly one result transaction whose tuser status
// reads enqueued, dropped because the queue was full, granted, or nothing
// waiting. An enqueue result is registered straight from the command, while a
// grant first registers the queue memory read before the result is formed.
// A two-entry command queue at the front lets input transactions keep
// arriving while a result waits for rsp_tready. Configuration writes go through
// csr_we, csr_index and csr_wdata and are meant to be issued while the block is
// idle; writing start_direction also restarts the burst in that direction.
module four_way_burst_round_robin_scheduler_top
   import fwbrr_pkg::*;
#(
   parameter int QUEUE_DEPTH = 16
)
(
   input  logic        clock,
   input  logic        reset,
   // Request transactions.
   input  logic        req_tvalid,
   output logic        req_tready,
   // Fields from bit 0: direction[1:0], tag[25:2], duration[29:26], zero pad.
   input  logic [31:0] req_tdata,
   // Field: command (0 enqueue, 1 serve).
   input  logic        req_tuser,
   // Result transactions.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // Fields from bit 0: granted_direction[1:0], granted_tag[25:2],
   // granted_duration[29:26], new_burst[30], zero pad.
   output logic [31:0] rsp_tdata,
   // Field: status[1:0].
   output logic [1:0]  rsp_tuser,
   // Configuration write port: index 0 start_direction, index 1 max_burst.
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [7:0]  csr_wdata
);

   // Classified commands handed from the front queue to the scheduler.
   cmd_type cmd;
   logic    cmd_valid;
   logic    cmd_ready;

   fwbrr_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .cmd_valid  (cmd_valid),
      .cmd_ready  (cmd_ready),
      .cmd        (cmd)
   );

   // The back end holds the direction queues, the arbitration state and the
   // result register.
   fwbrr_back #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .cmd_valid  (cmd_valid),
      .cmd_ready  (cmd_ready),
      .cmd        (cmd),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule
